FILE: design/gsa_pkg.sv
// ----------------------------------------------------------------------------
// gsa_pkg: shared types and constants for the scaled matrix multiply block
// Holds opcodes, register indexes, status codes and the front/back request.
// ----------------------------------------------------------------------------
package gsa_pkg;

    localparam int unsigned DIM_W  = 4;
    localparam int unsigned IDX_W  = 3;
    localparam int unsigned VAL_W  = 32;
    localparam int unsigned ADDR_W = 6;
    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [1:0] {
        MODE_LOAD_A  = 2'd0,
        MODE_LOAD_B  = 2'd1,
        MODE_LOAD_C  = 2'd2,
        MODE_COMPUTE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_SAT   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        REG_ROWS_N  = 3'd0,
        REG_INNER_M = 3'd1,
        REG_COLS_P  = 3'd2,
        REG_ALPHA   = 3'd3,
        REG_BETA    = 3'd4,
        REG_TRANS_A = 3'd5,
        REG_TRANS_B = 3'd6
    } t_reg;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_DOT_RD,
        BK_DOT_MUL,
        BK_DOT_ACC,
        BK_C_RD,
        BK_C_MUL,
        BK_AH_MUL,
        BK_AM_MUL,
        BK_AL_MUL,
        BK_SUM,
        BK_EMIT,
        BK_LOAD
    } t_bk_state;

    // classified request from front to back
    typedef struct packed {
        logic        compute;
        logic        in_range;
        logic [1:0]  mode;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] value;
    } t_req;

    // clamp a dimension register to 1..8
    function automatic logic [3:0] clamp_dim(input logic [3:0] d);
        logic [3:0] r;
        r = d;
        if (d == 4'd0) r = 4'd1;
        else if (d > 4'd8) r = 4'd8;
        return r;
    endfunction

endpackage

FILE: design/gsa_if.sv
// ----------------------------------------------------------------------------
// gsa_if: valid/ready channel interfaces
// Item input, result output and register write channels.
// ----------------------------------------------------------------------------
interface gsa_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [31:0] value;
    modport source (output valid, mode, row, col, value, input ready);
    modport sink (input valid, mode, row, col, value, output ready);
endinterface

interface gsa_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  out_row;
    logic [2:0]  out_col;
    logic [31:0] out_value;
    logic        last;
    logic [1:0]  status;
    modport source (output valid, out_row, out_col, out_value, last, status, input ready);
    modport sink (input valid, out_row, out_col, out_value, last, status, output ready);
endinterface

interface gsa_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: design/gsa_ram.sv
// ----------------------------------------------------------------------------
// gsa_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gsa_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: design/gsa_front.sv
// ----------------------------------------------------------------------------
// gsa_front: request intake and classification
// Checks load bounds against the configured shapes and queues requests.
// ----------------------------------------------------------------------------
module gsa_front import gsa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gsa_in_if.sink      in_ch,
    input  logic [3:0]  i_n,
    input  logic [3:0]  i_m,
    input  logic [3:0]  i_p,
    input  logic        i_ta,
    input  logic        i_tb,
    input  logic        i_pop,
    output logic        o_q_valid,
    output t_req        o_q_req,
    output logic        o_busy
);
    localparam int unsigned QD = 2;
    t_req       r_q [QD];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic [3:0] lim_r, lim_c;
    logic       push;
    t_req       req;

    always_comb begin
        case (t_mode'(in_ch.mode))
            MODE_LOAD_A: begin
                lim_r = i_ta ? i_m : i_n;
                lim_c = i_ta ? i_n : i_m;
            end
            MODE_LOAD_B: begin
                lim_r = i_tb ? i_p : i_m;
                lim_c = i_tb ? i_m : i_p;
            end
            default: begin
                lim_r = i_n;
                lim_c = i_p;
            end
        endcase
        req.compute  = (in_ch.mode == MODE_COMPUTE);
        req.in_range = ({1'b0, in_ch.row} < lim_r) && ({1'b0, in_ch.col} < lim_c);
        req.mode     = in_ch.mode;
        req.row      = in_ch.row;
        req.col      = in_ch.col;
        req.value    = in_ch.value;
    end

    assign in_ch.ready = (r_cnt != 2'(QD));
    assign push        = in_ch.valid && in_ch.ready;
    assign o_q_valid   = (r_cnt != 2'd0);
    assign o_q_req     = r_q[r_rp];
    assign o_busy      = o_q_valid;

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= req;
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'(QD))
        else $error("queue overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_pop |-> o_q_valid)
        else $error("pop from empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'(QD)) |-> !in_ch.ready)
        else $error("ready while full");
endmodule

FILE: design/gsa_back.sv
// ----------------------------------------------------------------------------
// gsa_back: store writes and multiply-accumulate sequencer
// One shared 32x32 multiplier walks each C element over the inner dimension.
// ----------------------------------------------------------------------------
module gsa_back import gsa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_req        i_q_req,
    output logic        o_pop,
    input  logic [3:0]  i_n,
    input  logic [3:0]  i_m,
    input  logic [3:0]  i_p,
    input  logic        i_ta,
    input  logic        i_tb,
    input  logic [31:0] i_alpha,
    input  logic [31:0] i_beta,
    gsa_out_if.source   out_ch,
    output logic        o_busy
);
    t_bk_state r_st, n_st;
    logic [2:0] r_i, n_i, r_j, n_j, r_k, n_k;
    logic signed [63:0] r_prod, n_prod;
    logic signed [51:0] r_dot, n_dot;   // sum of up to 8 products >> 16
    logic signed [47:0] r_extra, n_extra;
    logic signed [71:0] r_res, n_res;
    t_req        r_req, n_req;
    logic        r_ov, n_ov;
    logic [2:0]  r_orow, n_orow, r_ocol, n_ocol;
    logic [31:0] r_oval, n_oval;
    logic        r_olast, n_olast;
    logic [1:0]  r_ostat, n_ostat;

    logic [5:0]  a_ra, b_ra, c_ra, c_wa;
    logic [31:0] a_rd, b_rd, c_rd, c_wd;
    logic        a_we, b_we, c_we;
    logic [31:0] ld_wd;
    logic [5:0]  ld_wa;
    logic        out_free;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_y;
    logic signed [31:0] d_hi, d_mid, d_lo;
    logic signed [71:0] sum;

    assign ld_wa = {r_req.row, r_req.col};
    assign ld_wd = r_req.value;
    assign a_ra  = i_ta ? {r_k, r_i} : {r_i, r_k};
    assign b_ra  = i_tb ? {r_j, r_k} : {r_k, r_j};
    assign c_ra  = {r_i, r_j};

    gsa_ram #(.WIDTH(32), .DEPTH(64)) u_a (.i_clk, .i_we(a_we), .i_waddr(ld_wa),
        .i_wdata(ld_wd), .i_raddr(a_ra), .o_rdata(a_rd));
    gsa_ram #(.WIDTH(32), .DEPTH(64)) u_b (.i_clk, .i_we(b_we), .i_waddr(ld_wa),
        .i_wdata(ld_wd), .i_raddr(b_ra), .o_rdata(b_rd));
    gsa_ram #(.WIDTH(32), .DEPTH(64)) u_c (.i_clk, .i_we(c_we), .i_waddr(c_wa),
        .i_wdata(c_wd), .i_raddr(c_ra), .o_rdata(c_rd));

    assign out_free = !r_ov || out_ch.ready;
    assign mul_y    = mul_a * mul_b;
    assign d_hi     = {{12{r_dot[51]}}, r_dot[51:32]};
    assign d_mid    = {16'd0, r_dot[31:16]};
    assign d_lo     = {16'd0, r_dot[15:0]};
    assign sum      = r_res + 72'(r_prod >>> 16) + 72'(r_extra);

    always_comb begin
        n_st = r_st; n_i = r_i; n_j = r_j; n_k = r_k;
        n_prod = r_prod; n_dot = r_dot; n_extra = r_extra;
        n_res = r_res; n_req = r_req;
        n_ov = r_ov && !out_ch.ready;
        n_orow = r_orow; n_ocol = r_ocol; n_oval = r_oval;
        n_olast = r_olast; n_ostat = r_ostat;
        o_pop = 1'b0;
        a_we = 1'b0; b_we = 1'b0; c_we = 1'b0;
        c_wa = ld_wa; c_wd = ld_wd;
        mul_a = $signed(a_rd); mul_b = $signed(b_rd);
        case (r_st)
            BK_IDLE: begin
                if (i_q_valid) begin
                    o_pop = 1'b1;
                    n_req = i_q_req;
                    n_i = 3'd0; n_j = 3'd0; n_k = 3'd0; n_dot = '0;
                    n_st = i_q_req.compute ? BK_DOT_RD : BK_LOAD;
                end
            end
            BK_LOAD: begin
                if (out_free) begin
                    if (r_req.in_range) begin
                        a_we = (r_req.mode == MODE_LOAD_A);
                        b_we = (r_req.mode == MODE_LOAD_B);
                        c_we = (r_req.mode == MODE_LOAD_C);
                    end
                    n_ov = 1'b1;
                    n_orow = r_req.row; n_ocol = r_req.col; n_oval = '0;
                    n_olast = 1'b1;
                    n_ostat = r_req.in_range ? ST_OK : ST_RANGE;
                    n_st = BK_IDLE;
                end
            end
            BK_DOT_RD: n_st = BK_DOT_MUL;
            BK_DOT_MUL: begin
                n_prod = mul_y;
                n_st = BK_DOT_ACC;
            end
            BK_DOT_ACC: begin
                n_dot = r_dot + 52'(r_prod >>> 16);
                if ({1'b0, r_k} == i_m - 4'd1) begin
                    n_st = BK_C_RD;
                end else begin
                    n_k = r_k + 3'd1;
                    n_st = BK_DOT_RD;
                end
            end
            BK_C_RD: n_st = BK_C_MUL;
            BK_C_MUL: begin
                mul_a = $signed(i_beta); mul_b = $signed(c_rd);
                n_extra = 48'(mul_y >>> 16);
                n_st = BK_AH_MUL;
            end
            BK_AH_MUL: begin
                mul_a = $signed(i_alpha); mul_b = d_hi;
                n_res = 72'(mul_y) <<< 16;
                n_st = BK_AM_MUL;
            end
            BK_AM_MUL: begin
                mul_a = $signed(i_alpha); mul_b = d_mid;
                n_res = r_res + 72'(mul_y);
                n_st = BK_AL_MUL;
            end
            BK_AL_MUL: begin
                mul_a = $signed(i_alpha); mul_b = d_lo;
                n_prod = mul_y;
                n_st = BK_SUM;
            end
            BK_SUM: begin
                n_res = sum;
                n_st = BK_EMIT;
            end
            BK_EMIT: begin
                if (out_free) begin
                    n_ov = 1'b1; n_orow = r_i; n_ocol = r_j;
                    n_olast = ({1'b0, r_i} == i_n - 4'd1) && ({1'b0, r_j} == i_p - 4'd1);
                    if (r_res > 72'sh7FFF_FFFF) begin
                        n_oval = 32'h7FFF_FFFF; n_ostat = ST_SAT;
                    end else if (r_res < -72'sh8000_0000) begin
                        n_oval = 32'h8000_0000; n_ostat = ST_SAT;
                    end else begin
                        n_oval = r_res[31:0]; n_ostat = ST_OK;
                    end
                    c_we = 1'b1; c_wa = {r_i, r_j}; c_wd = n_oval;
                    n_k = 3'd0; n_dot = '0;
                    if (n_olast) begin
                        n_st = BK_IDLE;
                    end else begin
                        if ({1'b0, r_j} == i_p - 4'd1) begin
                            n_j = 3'd0; n_i = r_i + 3'd1;
                        end else begin
                            n_j = r_j + 3'd1;
                        end
                        n_st = BK_DOT_RD;
                    end
                end
            end
            default: n_st = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i; r_j <= n_j; r_k <= n_k; r_prod <= n_prod; r_dot <= n_dot;
        r_extra <= n_extra; r_res <= n_res; r_req <= n_req;
        r_orow <= n_orow; r_ocol <= n_ocol; r_oval <= n_oval;
        r_olast <= n_olast; r_ostat <= n_ostat;
        if (!i_rst_n) begin
            r_st <= BK_IDLE;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            r_ov <= n_ov;
        end
    end

    assign out_ch.valid     = r_ov;
    assign out_ch.out_row   = r_orow;
    assign out_ch.out_col   = r_ocol;
    assign out_ch.out_value = r_oval;
    assign out_ch.last      = r_olast;
    assign out_ch.status    = r_ostat;
    assign o_busy           = (r_st != BK_IDLE) || r_ov;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !out_ch.ready) |=> r_ov && $stable(r_oval))
        else $error("result lost under stall");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_st == BK_IDLE)
        else $error("pop while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_we || b_we) |-> (r_st == BK_LOAD) && r_req.in_range)
        else $error("stray store write");
endmodule

FILE: design/gemm_scaled_accumulate_top.sv
// ----------------------------------------------------------------------------
// gemm_scaled_accumulate_top: C = beta*C + alpha*op(A)*op(B), Q16.16
//
//   channel   dir   handshake       payload
//   in_ch     in    valid/ready     mode, row, col, value
//   out_ch    out   valid/ready     out_row, out_col, out_value, last, status
//   cfg_ch    in    valid/ready     index, data
//
// A load waits in the load state until the output is free. A compute steps
// each C element over the inner index (read, multiply, accumulate), then the
// beta and alpha products, paced by one shared multiplier and registered reads.
// Synchronous active-low reset clears control and loads register defaults.
// Stores are undefined after reset. A two-entry queue decouples intake from
// the sequencer; a stalled output holds the sequencer in its load or emit state.
// ----------------------------------------------------------------------------
module gemm_scaled_accumulate_top import gsa_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    gsa_in_if.sink  in_ch,
    gsa_out_if.source out_ch,
    gsa_cfg_if.sink cfg_ch
);
    logic [3:0]  r_n, r_m, r_p;
    logic [31:0] r_alpha, r_beta;
    logic        r_ta, r_tb;
    logic [3:0]  n, m, p;
    logic        q_valid, pop, fb, bb;
    t_req        q_req;

    assign n = clamp_dim(r_n);
    assign m = clamp_dim(r_m);
    assign p = clamp_dim(r_p);
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= 4'd8; r_m <= 4'd8; r_p <= 4'd8;
            r_alpha <= 32'h0001_0000; r_beta <= '0;
            r_ta <= 1'b0; r_tb <= 1'b0;
        end else if (cfg_ch.valid) begin
            case (t_reg'(cfg_ch.index))
                REG_ROWS_N:  r_n <= cfg_ch.data[3:0];
                REG_INNER_M: r_m <= cfg_ch.data[3:0];
                REG_COLS_P:  r_p <= cfg_ch.data[3:0];
                REG_ALPHA:   r_alpha <= cfg_ch.data;
                REG_BETA:    r_beta <= cfg_ch.data;
                REG_TRANS_A: r_ta <= cfg_ch.data[0];
                REG_TRANS_B: r_tb <= cfg_ch.data[0];
                default: ;
            endcase
        end
    end

    gsa_front u_front (.i_clk, .i_rst_n, .in_ch, .i_n(n), .i_m(m), .i_p(p),
        .i_ta(r_ta), .i_tb(r_tb), .i_pop(pop), .o_q_valid(q_valid),
        .o_q_req(q_req), .o_busy(fb));

    gsa_back u_back (.i_clk, .i_rst_n, .i_q_valid(q_valid), .i_q_req(q_req),
        .o_pop(pop), .i_n(n), .i_m(m), .i_p(p), .i_ta(r_ta), .i_tb(r_tb),
        .i_alpha(r_alpha), .i_beta(r_beta), .out_ch, .o_busy(bb));

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> (fb || bb))
        else $error("result with idle back end");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_ch.valid && out_ch.last && out_ch.status == ST_RANGE) |-> out_ch.out_value == 32'd0)
        else $error("range status with data");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n >= 4'd1) && (n <= 4'd8) && (m >= 4'd1) && (p <= 4'd8))
        else $error("dimension clamp");
endmodule
